// ===== design/cnm_pkg.sv =====
// ----------------------------------------------------------------------------
// cnm_pkg
// Shared constants, types and the quarter-wave oscillator tables of the
// complex NCO mixer.
// ----------------------------------------------------------------------------
package cnm_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS     = 16;
    localparam int STEP_BITS       = 32;

    localparam int QTR_BITS     = TABLE_ADDR_BITS - 2;
    localparam int QTR_DEPTH    = 1 << QTR_BITS;
    localparam int AMP_BITS     = SAMPLE_BITS - 1;
    localparam int TAYLOR_TERMS = 8;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] AMP         = (64'd1 << AMP_BITS) - 64'd1;

    typedef logic signed [SAMPLE_BITS-1:0]     sample_t;
    typedef logic [TABLE_ADDR_BITS-1:0]        addr_t;
    typedef logic [STEP_BITS-1:0]              step_t;
    typedef logic [PHASE_BITS-1:0]             phase_t;
    typedef logic [AMP_BITS-1:0]               amp_t;
    typedef logic [QTR_DEPTH-1:0][AMP_BITS-1:0] rom_t;

    // quadrant codes (top two bits of the table address)
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic mul_en;
        logic out_en;
    } rot_ctrl_t;

    // Unsigned long division by shift and subtract; only builds the tables.
    function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Truncated Q2.30 Taylor series, clamped to [0, 1.0]; odd selects sine.
    function automatic logic [63:0] taylor_q30(logic [63:0] x, logic odd);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        n;
        logic signed [65:0] sum;
        x2   = (x * x) >> 30;
        term = odd ? x : Q30_ONE;
        n    = odd ? 64'd1 : 64'd0;
        sum  = '0;
        for (int k = 0; k < TAYLOR_TERMS; k++)
        begin
            if ((k & 1) == 1)
                sum = sum - $signed({2'b00, term});
            else
                sum = sum + $signed({2'b00, term});
            term = div_u64((term * x2) >> 30, (n + 64'd1) * (n + 64'd2));
            n    = n + 64'd2;
        end
        if (sum < 0)
            sum = '0;
        if (sum > $signed({2'b00, Q30_ONE}))
            sum = $signed({2'b00, Q30_ONE});
        return sum[63:0];
    endfunction

    function automatic amp_t scale_amp(logic [63:0] q30);
        logic [63:0] v;
        v = (q30 * AMP + (64'd1 << 29)) >> 30;
        if (v > AMP)
            v = AMP;
        return v[AMP_BITS-1:0];
    endfunction

    function automatic rom_t build_rom(logic odd);
        rom_t        rom;
        logic [63:0] t;
        for (int r = 0; r < QTR_DEPTH; r++)
        begin
            t      = (64'(r) * HALF_PI_Q30) >> QTR_BITS;
            rom[r] = scale_amp(taylor_q30(t, odd));
        end
        return rom;
    endfunction

    localparam rom_t SIN_ROM = build_rom(1'b1);
    localparam rom_t COS_ROM = build_rom(1'b0);

endpackage

// ===== design/cnm_nco.sv =====
// ----------------------------------------------------------------------------
// cnm_nco
// Phase step register and phase accumulator; gives the table address of the
// sample about to be taken.
// ----------------------------------------------------------------------------
module cnm_nco (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    input  cnm_pkg::step_t cfg_data,
    input  logic           load,
    input  logic           last,
    output cnm_pkg::addr_t phase_addr
);
    import cnm_pkg::*;

    step_t  step_reg;
    phase_t acc_reg;
    phase_t acc_next;
    phase_t step_ext;

    // sign-extend (or wrap) the 32-bit step to the accumulator width
    assign step_ext   = PHASE_BITS'($signed(step_reg));
    assign acc_next   = last ? '0 : acc_reg + step_ext;
    assign phase_addr = acc_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
                step_reg <= cfg_data;
            if (load)
                acc_reg <= acc_next;
        end
    end

    a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load && last |=> acc_reg == '0)
        else $error("phase not cleared after end of block");

    a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
        load && !last && !cfg_valid |=> acc_reg == $past(acc_reg) + $past(step_ext))
        else $error("phase did not advance by step");

endmodule

// ===== design/cnm_osc_rom.sv =====
// ----------------------------------------------------------------------------
// cnm_osc_rom
// Quarter-wave sine/cosine lookup with quadrant folding; registered output.
// ----------------------------------------------------------------------------
module cnm_osc_rom (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  cnm_pkg::addr_t   addr,
    output cnm_pkg::sample_t osc_cos,
    output cnm_pkg::sample_t osc_sin
);
    import cnm_pkg::*;

    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [QTR_BITS-1:0] r;
    logic [1:0]          quad;
    sample_t             cv;
    sample_t             sv;
    sample_t             cos_next;
    sample_t             sin_next;
    sample_t             cos_reg;
    sample_t             sin_reg;

    assign r    = addr[QTR_BITS-1:0];
    assign quad = addr[TABLE_ADDR_BITS-1 -: 2];
    assign cv   = sample_t'({1'b0, COS_ROM[r]});
    assign sv   = sample_t'({1'b0, SIN_ROM[r]});

    always_comb
    begin
        case (quad)
            QUAD_0:
            begin
                cos_next = cv;
                sin_next = sv;
            end
            QUAD_1:
            begin
                cos_next = -sv;
                sin_next = cv;
            end
            QUAD_2:
            begin
                cos_next = -cv;
                sin_next = -sv;
            end
            QUAD_3:
            begin
                cos_next = sv;
                sin_next = -cv;
            end
            default:
            begin
                cos_next = cv;
                sin_next = sv;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign osc_cos = cos_reg;
    assign osc_sin = sin_reg;

    // table values never reach full-scale negative
    a_osc_range: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> cos_reg != SAMPLE_MIN && sin_reg != SAMPLE_MIN)
        else $error("oscillator value out of range");

endmodule

// ===== design/cnm_rotate.sv =====
// ----------------------------------------------------------------------------
// cnm_rotate
// Complex multiply by the oscillator: product stage, then sum, round half up
// and saturate into the output registers.
// ----------------------------------------------------------------------------
module cnm_rotate (
    input  logic               clk,
    input  cnm_pkg::rot_ctrl_t ctrl,
    input  cnm_pkg::sample_t   a,
    input  cnm_pkg::sample_t   b,
    input  cnm_pkg::sample_t   c,
    input  cnm_pkg::sample_t   s,
    output cnm_pkg::sample_t   mixed_i,
    output cnm_pkg::sample_t   mixed_q
);
    import cnm_pkg::*;

    localparam int PROD_BITS = 2 * SAMPLE_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam logic signed [SUM_BITS-1:0] SUM_HI  = (SUM_BITS'(1) <<< (SAMPLE_BITS-1)) - 1;
    localparam logic signed [SUM_BITS-1:0] SUM_LO  = -(SUM_BITS'(1) <<< (SAMPLE_BITS-1));
    localparam logic signed [SUM_BITS-1:0] HALF_LSB = SUM_BITS'(1) <<< (SAMPLE_BITS-2);

    logic signed [PROD_BITS-1:0] ac_reg;
    logic signed [PROD_BITS-1:0] bs_reg;
    logic signed [PROD_BITS-1:0] as_reg;
    logic signed [PROD_BITS-1:0] bc_reg;
    logic signed [SUM_BITS-1:0]  sum_i;
    logic signed [SUM_BITS-1:0]  sum_q;
    sample_t                     mixed_i_reg;
    sample_t                     mixed_q_reg;

    function automatic sample_t round_sat(logic signed [SUM_BITS-1:0] v);
        logic signed [SUM_BITS-1:0] q;
        q = (v + HALF_LSB) >>> (SAMPLE_BITS-1);
        if (q > SUM_HI)
            q = SUM_HI;
        else if (q < SUM_LO)
            q = SUM_LO;
        return q[SAMPLE_BITS-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            ac_reg <= PROD_BITS'(a * c);
            bs_reg <= PROD_BITS'(b * s);
            as_reg <= PROD_BITS'(a * s);
            bc_reg <= PROD_BITS'(b * c);
        end
    end

    assign sum_i = SUM_BITS'(ac_reg) - SUM_BITS'(bs_reg);
    assign sum_q = SUM_BITS'(as_reg) + SUM_BITS'(bc_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.out_en)
        begin
            mixed_i_reg <= round_sat(sum_i);
            mixed_q_reg <= round_sat(sum_q);
        end
    end

    assign mixed_i = mixed_i_reg;
    assign mixed_q = mixed_q_reg;

endmodule

// ===== design/complex_nco_mixer_core.sv =====
// ----------------------------------------------------------------------------
// complex_nco_mixer_core
// NCO and complex mixer: rotates each I/Q sample by cos + j*sin of a phase
// accumulator, result rounded and saturated to Q1.15.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_data write the signed 32-bit phase step; cfg_ready is
//   always high. Write it only while the block is empty.
//   Input transfer: in_valid high and in_stall low at a rising edge.
//   Output transfer: out_valid high and out_stall low at a rising edge.
//   Pipeline: input register, oscillator table register, product register,
//   output register. One sample per clock is sustained while out_stall is
//   low. Each stage has its own valid bit, so bubbles collapse while the
//   output is stalled and the input is only stalled once all four
//   stages are full.
//   The phase advances by the step on each accepted sample and returns to
//   zero after a sample with last_in_block set.
//   Reset clears the phase, the step and all valid bits.
// ----------------------------------------------------------------------------
module complex_nco_mixer_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  cnm_pkg::step_t   cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  cnm_pkg::sample_t sample_i,
    input  cnm_pkg::sample_t sample_q,
    input  logic             last_in_block,
    output logic             out_valid,
    input  logic             out_stall,
    output cnm_pkg::sample_t mixed_i,
    output cnm_pkg::sample_t mixed_q,
    output logic             last_out
);
    import cnm_pkg::*;

    logic      v0_reg, v1_reg, v2_reg, v3_reg;
    logic      rdy0, rdy1, rdy2, rdy3;
    logic      accept;
    addr_t     phase_addr;
    rot_ctrl_t rot_ctrl;
    sample_t   osc_cos, osc_sin;

    sample_t   s0_i_reg, s0_q_reg;
    logic      s0_last_reg;
    addr_t     s0_addr_reg;
    sample_t   s1_i_reg, s1_q_reg;
    logic      s1_last_reg, s2_last_reg, s3_last_reg;

    assign rdy3   = !v3_reg || !out_stall;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || rdy2;
    assign rdy0   = !v0_reg || rdy1;
    assign accept = in_valid && rdy0;

    assign in_stall  = !rdy0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= in_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_i_reg    <= sample_i;
            s0_q_reg    <= sample_q;
            s0_last_reg <= last_in_block;
            s0_addr_reg <= phase_addr;
        end
        if (rdy1)
        begin
            s1_i_reg    <= s0_i_reg;
            s1_q_reg    <= s0_q_reg;
            s1_last_reg <= s0_last_reg;
        end
        if (rdy2)
            s2_last_reg <= s1_last_reg;
        if (rdy3)
            s3_last_reg <= s2_last_reg;
    end

    cnm_nco u_nco (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .load       (accept),
        .last       (last_in_block),
        .phase_addr (phase_addr)
    );

    // table register only loads a valid address
    cnm_osc_rom u_osc (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (rdy1 && v0_reg),
        .addr    (s0_addr_reg),
        .osc_cos (osc_cos),
        .osc_sin (osc_sin)
    );

    assign rot_ctrl.mul_en = rdy2;
    assign rot_ctrl.out_en = rdy3;

    cnm_rotate u_rot (
        .clk     (clk),
        .ctrl    (rot_ctrl),
        .a       (s1_i_reg),
        .b       (s1_q_reg),
        .c       (osc_cos),
        .s       (osc_sin),
        .mixed_i (mixed_i),
        .mixed_q (mixed_q)
    );

    assign out_valid = v3_reg;
    assign last_out  = s3_last_reg;

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v0_reg && v1_reg && v2_reg && v3_reg)
        else $error("input stalled with a free pipeline stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !out_stall && !v2_reg |=> !out_valid)
        else $error("result repeated after transfer");

endmodule
